@@ rtl/rslr_pkg.sv @@
`timescale 1ns / 1ps

package rslr_pkg;

    localparam int CLIENTS     = 64;
    localparam int CLIENT_BITS = $clog2(CLIENTS);
    localparam int MAX_LIMIT   = 16;
    localparam int HEAD_BITS   = $clog2(MAX_LIMIT);
    localparam int CNT_BITS    = $clog2(MAX_LIMIT + 1);
    localparam int LIMIT_BITS  = $clog2(MAX_LIMIT + 1);
    localparam int TIME_BITS   = 48;
    localparam int WIN_BITS    = 32;
    localparam int NLIM_BITS   = 8;
    localparam int DLIM_BITS   = 5;
    localparam int LOG_DEPTH   = CLIENTS * MAX_LIMIT;
    localparam int LOG_AW      = CLIENT_BITS + HEAD_BITS;
    localparam int STAT_BITS   = 2;

    // input tdata layout, lowest field first
    localparam int IN_DATA_RAW  = CLIENT_BITS + TIME_BITS + NLIM_BITS + WIN_BITS;
    localparam int IN_DATA_BITS = ((IN_DATA_RAW + 7) / 8) * 8;
    localparam int OUT_DATA_BITS = WIN_BITS;

    localparam int CFG_AW   = 1;
    localparam int CFG_DW   = WIN_BITS;

    localparam logic [CFG_AW-1:0] CFG_DEFAULT_LIMIT  = 1'd0;
    localparam logic [CFG_AW-1:0] CFG_DEFAULT_WINDOW = 1'd1;

    localparam logic [DLIM_BITS-1:0] DEF_LIMIT_RST  = 5'd10;
    localparam logic [WIN_BITS-1:0]  DEF_WINDOW_RST = 32'd1000;

    localparam logic MODE_REQUEST  = 1'b0;
    localparam logic MODE_RECONFIG = 1'b1;

    localparam logic [STAT_BITS-1:0] STAT_ALLOWED  = 2'd0;
    localparam logic [STAT_BITS-1:0] STAT_DENIED   = 2'd1;
    localparam logic [STAT_BITS-1:0] STAT_RECONFIG = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TAB,
        ST_AGE,
        ST_CMP,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [LIMIT_BITS-1:0] limit;
        logic [WIN_BITS-1:0]   window;
        logic [HEAD_BITS-1:0]  head;
        logic [CNT_BITS-1:0]   count;
    } t_client;

    function automatic logic [LIMIT_BITS-1:0] sat_limit(input logic [NLIM_BITS-1:0] v);
        logic [LIMIT_BITS-1:0] r;
        if (v > NLIM_BITS'(MAX_LIMIT)) begin
            r = LIMIT_BITS'(MAX_LIMIT);
        end else begin
            r = v[LIMIT_BITS-1:0];
        end
        return r;
    endfunction

endpackage

@@ rtl/sliding_log_rate_limiter_unit.sv @@
// Per-client sliding-window log rate limiter. Each of the 64 client slots keeps a limit,
// a window and a ring of up to 16 request times in an internal log memory. A request
// (tuser 0) drops expired times oldest first, then is allowed and logged if fewer times
// than the limit remain, else denied with retry_after = window minus age of the oldest
// time. A reconfigure (tuser 1) sets the slot's limit and window. One item is in work at
// a time: a request reads the client table, then the log memory, then passes the shared
// age subtractor and window compare, once more for each expired time dropped, and
// presents its result with tready returning in that same cycle; a reconfigure reads
// the table, writes it back and presents its result the same way; a stalled result port
// adds its stall. The client table is empty right after reset with no clearing pass.
// The user writes default limit and window through the cfg port only while no request
// is in work; the block itself does not enforce this.
`timescale 1ns / 1ps

module sliding_log_rate_limiter_unit
    import rslr_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_s_axis_tvalid,
    output logic                     o_s_axis_tready,
    // client_id, timestamp, new_limit, new_window, zero fill
    input  logic [IN_DATA_BITS-1:0]  i_s_axis_tdata,
    // mode
    input  logic                     i_s_axis_tuser,
    output logic                     o_m_axis_tvalid,
    input  logic                     i_m_axis_tready,
    // retry_after
    output logic [OUT_DATA_BITS-1:0] o_m_axis_tdata,
    // status
    output logic [STAT_BITS-1:0]     o_m_axis_tuser,
    input  logic                     i_cfg_we,
    input  logic [CFG_AW-1:0]        i_cfg_addr,
    input  logic [CFG_DW-1:0]        i_cfg_wdata
);

    localparam int TS_LO = CLIENT_BITS;
    localparam int NL_LO = TS_LO + TIME_BITS;
    localparam int NW_LO = NL_LO + NLIM_BITS;

    t_state r_state, n_state;

    logic [DLIM_BITS-1:0]   r_def_limit;
    logic [WIN_BITS-1:0]    r_def_window;

    logic                   r_mode;
    logic [CLIENT_BITS-1:0] r_cid;
    logic [TIME_BITS-1:0]   r_now;
    logic [NLIM_BITS-1:0]   r_nl;
    logic [WIN_BITS-1:0]    r_nw;

    logic [LIMIT_BITS-1:0]  r_lim, n_lim;
    logic [WIN_BITS-1:0]    r_win, n_win;
    logic [HEAD_BITS-1:0]   r_head, n_head;
    logic [CNT_BITS-1:0]    r_cnt, n_cnt;
    logic [TIME_BITS-1:0]   r_age, n_age;
    logic [STAT_BITS-1:0]   r_res_status, n_res_status;
    logic [WIN_BITS-1:0]    r_res_retry, n_res_retry;

    logic                   r_out_valid;
    logic [STAT_BITS-1:0]   r_out_status;
    logic [WIN_BITS-1:0]    r_out_retry;

    logic [TIME_BITS-1:0]   r_log [LOG_DEPTH];
    logic [TIME_BITS-1:0]   r_log_q;
    logic                   log_rd_en, log_wr_en;
    logic [LOG_AW-1:0]      log_rd_addr, log_wr_addr;

    logic                   tab_rd_en, tab_wr_en;
    t_client                tab_rd, tab_wr;

    logic                   in_acc, out_free, expired, over;

    assign in_acc   = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free = !r_out_valid || i_m_axis_tready;
    assign expired  = (r_cnt != '0) && (r_age >= {{(TIME_BITS-WIN_BITS){1'b0}}, r_win});
    assign over     = r_cnt >= CNT_BITS'(r_lim);

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_retry;
    assign o_m_axis_tuser  = r_out_status;

    rslr_client_tab u_tab (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rd_en      (tab_rd_en),
        .i_rd_addr    (i_s_axis_tdata[CLIENT_BITS-1:0]),
        .i_def_limit  (r_def_limit),
        .i_def_window (r_def_window),
        .o_rd_entry   (tab_rd),
        .i_wr_en      (tab_wr_en),
        .i_wr_addr    (r_cid),
        .i_wr_entry   (tab_wr)
    );

    always_ff @(posedge i_clk) begin
        if (log_wr_en) begin
            r_log[log_wr_addr] <= r_now;
        end
        if (log_rd_en) begin
            r_log_q <= r_log[log_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_def_limit  <= DEF_LIMIT_RST;
            r_def_window <= DEF_WINDOW_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_DEFAULT_LIMIT:  r_def_limit  <= i_cfg_wdata[DLIM_BITS-1:0];
                CFG_DEFAULT_WINDOW: r_def_window <= i_cfg_wdata[WIN_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (in_acc) n_state = ST_TAB;
            ST_TAB:  n_state = (r_mode == MODE_RECONFIG) ? ST_DONE : ST_AGE;
            ST_AGE:  n_state = ST_CMP;
            ST_CMP:  n_state = expired ? ST_AGE : ST_DONE;
            ST_DONE: if (out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        tab_rd_en    = 1'b0;
        tab_wr_en    = 1'b0;
        tab_wr       = '{limit: r_lim, window: r_win, head: r_head, count: r_cnt};
        log_rd_en    = 1'b0;
        log_rd_addr  = {r_cid, r_head};
        log_wr_en    = 1'b0;
        log_wr_addr  = {r_cid, r_head + r_cnt[HEAD_BITS-1:0]};
        n_lim        = r_lim;
        n_win        = r_win;
        n_head       = r_head;
        n_cnt        = r_cnt;
        n_age        = r_age;
        n_res_status = r_res_status;
        n_res_retry  = r_res_retry;
        unique case (r_state)
            ST_IDLE: begin
                tab_rd_en = in_acc;
            end
            ST_TAB: begin
                if (r_mode == MODE_RECONFIG) begin
                    tab_wr_en    = 1'b1;
                    tab_wr       = '{limit: sat_limit(r_nl), window: r_nw,
                                     head: tab_rd.head, count: tab_rd.count};
                    n_res_status = STAT_RECONFIG;
                    n_res_retry  = '0;
                end else begin
                    n_lim       = tab_rd.limit;
                    n_win       = tab_rd.window;
                    n_head      = tab_rd.head;
                    n_cnt       = tab_rd.count;
                    log_rd_en   = 1'b1;
                    log_rd_addr = {r_cid, tab_rd.head};
                end
            end
            ST_AGE: begin
                // time going backwards counts as age zero
                n_age = (r_now >= r_log_q) ? r_now - r_log_q : '0;
            end
            ST_CMP: begin
                if (expired) begin
                    n_head      = r_head + 1'b1;
                    n_cnt       = r_cnt - 1'b1;
                    log_rd_en   = 1'b1;
                    log_rd_addr = {r_cid, n_head};
                end else if (over) begin
                    tab_wr_en    = 1'b1;
                    n_res_status = STAT_DENIED;
                    n_res_retry  = (r_cnt == '0) ? r_win : r_win - r_age[WIN_BITS-1:0];
                end else begin
                    log_wr_en    = 1'b1;
                    n_cnt        = r_cnt + 1'b1;
                    tab_wr_en    = 1'b1;
                    tab_wr       = '{limit: r_lim, window: r_win, head: r_head, count: n_cnt};
                    n_res_status = STAT_ALLOWED;
                    n_res_retry  = '0;
                end
            end
            ST_DONE: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_mode <= i_s_axis_tuser;
            r_cid  <= i_s_axis_tdata[CLIENT_BITS-1:0];
            r_now  <= i_s_axis_tdata[NL_LO-1:TS_LO];
            r_nl   <= i_s_axis_tdata[NW_LO-1:NL_LO];
            r_nw   <= i_s_axis_tdata[NW_LO+WIN_BITS-1:NW_LO];
        end
        r_lim        <= n_lim;
        r_win        <= n_win;
        r_head       <= n_head;
        r_cnt        <= n_cnt;
        r_age        <= n_age;
        r_res_status <= n_res_status;
        r_res_retry  <= n_res_retry;
        // hold the result until taken
        if (r_state == ST_DONE && out_free) begin
            r_out_status <= r_res_status;
            r_out_retry  <= r_res_retry;
        end
    end

endmodule

@@ rtl/rslr_client_tab.sv @@
`timescale 1ns / 1ps

module rslr_client_tab
    import rslr_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_rd_en,
    input  logic [CLIENT_BITS-1:0] i_rd_addr,
    input  logic [DLIM_BITS-1:0]   i_def_limit,
    input  logic [WIN_BITS-1:0]    i_def_window,
    output t_client                o_rd_entry,
    input  logic                   i_wr_en,
    input  logic [CLIENT_BITS-1:0] i_wr_addr,
    input  t_client                i_wr_entry
);

    t_client                r_tab [CLIENTS];
    logic [CLIENTS-1:0]     r_known;
    t_client                r_q;
    logic                   r_known_q;
    t_client                w_def;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_tab[i_wr_addr] <= i_wr_entry;
        end
        if (i_rd_en) begin
            r_q <= r_tab[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_known   <= '0;
            r_known_q <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_known[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_known_q <= r_known[i_rd_addr];
            end
        end
    end

    // first touch of a slot sees the defaults and an empty log
    always_comb begin
        w_def.limit  = sat_limit({{(NLIM_BITS-DLIM_BITS){1'b0}}, i_def_limit});
        w_def.window = i_def_window;
        w_def.head   = '0;
        w_def.count  = '0;
    end

    assign o_rd_entry = r_known_q ? r_q : w_def;

endmodule

@@ rtl/rslr_checker.sv @@
`timescale 1ns / 1ps

module rslr_checker
    import rslr_pkg::*;
(
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_s_axis_tvalid,
    input logic                     o_s_axis_tready,
    input logic                     o_m_axis_tvalid,
    input logic                     i_m_axis_tready,
    input logic [OUT_DATA_BITS-1:0] o_m_axis_tdata,
    input logic [STAT_BITS-1:0]     o_m_axis_tuser
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("result changed while stalled");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            (o_m_axis_tuser == STAT_ALLOWED || o_m_axis_tuser == STAT_DENIED ||
             o_m_axis_tuser == STAT_RECONFIG))
        else $error("bad status code");

    a_retry_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser != STAT_DENIED |-> o_m_axis_tdata == '0)
        else $error("retry_after nonzero on a result that is not denied");

    // one request in work at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready ##1 !o_s_axis_tready)
        else $error("request accepted while busy");

endmodule

bind sliding_log_rate_limiter_unit rslr_checker u_rslr_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);
